FILE: src/twt_pkg.sv
// Shared types, constants and helpers for the trailing whitespace trimmer.
// Used by the front, command queue and back modules; depends on nothing.
package twt_pkg;

   // Character codes the trimmer recognizes.
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_VTAB    = 8'h0B;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // Deepest pending whitespace run, and the circular buffer that holds runs.
   localparam int WS_DEPTH     = 63;
   localparam int WS_BUF_DEPTH = 64;
   localparam int WS_ADDR_W    = $clog2(WS_BUF_DEPTH);
   localparam int WS_PTR_W     = WS_ADDR_W + 1;
   localparam int WS_CNT_W     = $clog2(WS_DEPTH + 1);

   localparam int QUEUE_DEPTH  = 4;
   localparam int Q_ADDR_W     = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] MAX_LINE_RESET = 16'd2000;

   // Two bit codes stored for each held whitespace byte.
   localparam logic [1:0] CODE_SPACE = 2'd0;
   localparam logic [1:0] CODE_TAB   = 2'd1;
   localparam logic [1:0] CODE_VTAB  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_NORMAL = 2'd0;
   localparam logic [1:0] STATUS_EOF    = 2'd1;
   localparam logic [1:0] STATUS_ERROR  = 2'd2;

   typedef enum logic [2:0] {
      CMD_SYNC,
      CMD_NEWLINE,
      CMD_CONTENT,
      CMD_EOF,
      CMD_ERROR
   } twt_cmd_kind_type;

   // One classified request. The back part releases count held codes from
   // start, then data for content; start + count is where its run ends.
   typedef struct packed {
      twt_cmd_kind_type      kind;
      logic [7:0]            data;
      logic [WS_PTR_W-1:0]   start;
      logic [WS_CNT_W-1:0]   count;
   } twt_cmd_type;

   typedef struct packed {
      logic                  en;
      logic [WS_ADDR_W-1:0]  addr;
      logic [1:0]            code;
   } twt_ws_wr_type;

   typedef struct packed {
      logic [WS_PTR_W-1:0]   tail;
   } twt_back_stat_type;

   function automatic logic [7:0] code_to_byte(input logic [1:0] code);
      logic [7:0] b;
      case (code)
         CODE_TAB:  b = CHAR_TAB;
         CODE_VTAB: b = CHAR_VTAB;
         default:   b = CHAR_SPACE;
      endcase
      return b;
   endfunction

endpackage

FILE: src/twt_front.sv
// Front part of the trimmer: accepts requests, keeps the per-line state and
// writes held whitespace codes. Depends on twt_pkg.
module twt_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [15:0]               csr_wr_data,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,
   input  logic                      req_tuser,
   input  logic                      q_full,
   output logic                      q_push,
   output twt_pkg::twt_cmd_type      q_cmd,
   output twt_pkg::twt_ws_wr_type    ws_wr,
   input  twt_pkg::twt_back_stat_type back_stat
);
   import twt_pkg::*;

   logic [WS_CNT_W-1:0] pending_ff, pending_in;
   logic                has_content_ff, has_content_in;
   logic                prev_blank_ff, prev_blank_in;
   logic [15:0]         line_count_ff, line_count_in;
   logic                error_hold_ff, error_hold_in;
   logic [WS_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [15:0]         max_len_ff, max_len_in;

   logic [WS_PTR_W-1:0] used;
   logic                buf_full;
   logic                accept;
   logic                is_ws;
   logic [1:0]          ws_code;

   // The buffer is full when every entry is still owed to the back part.
   assign used       = wr_ptr_ff - back_stat.tail;
   assign buf_full   = used[WS_PTR_W-1];
   assign req_tready = !q_full && !buf_full;
   assign accept     = req_tvalid && req_tready;

   assign is_ws = (req_tdata == CHAR_SPACE) || (req_tdata == CHAR_TAB) ||
                  (req_tdata == CHAR_VTAB);
   assign ws_code = (req_tdata == CHAR_SPACE) ? CODE_SPACE :
                    ((req_tdata == CHAR_TAB) ? CODE_TAB : CODE_VTAB);

   always_comb begin
      pending_in     = pending_ff;
      has_content_in = has_content_ff;
      prev_blank_in  = prev_blank_ff;
      line_count_in  = line_count_ff;
      error_hold_in  = error_hold_ff;
      wr_ptr_in      = wr_ptr_ff;
      max_len_in     = csr_wr_en ? csr_wr_data : max_len_ff;
      q_push         = 1'b0;
      q_cmd.kind     = CMD_SYNC;
      q_cmd.data     = req_tdata;
      q_cmd.start    = wr_ptr_ff;
      q_cmd.count    = '0;
      ws_wr.en       = 1'b0;
      ws_wr.addr     = wr_ptr_ff[WS_ADDR_W-1:0];
      ws_wr.code     = ws_code;
      if (accept) begin
         if (req_tuser) begin
            q_push         = 1'b1;
            q_cmd.kind     = CMD_EOF;
            pending_in     = '0;
            has_content_in = 1'b0;
            prev_blank_in  = 1'b0;
            line_count_in  = '0;
            error_hold_in  = 1'b0;
         end else if (error_hold_ff) begin
            q_push = 1'b0;
         end else if ((line_count_ff >= max_len_ff) ||
                      (is_ws && (pending_ff == WS_CNT_W'(WS_DEPTH)))) begin
            // Too long a line or too deep a run: one error, then silence.
            q_push        = 1'b1;
            q_cmd.kind    = CMD_ERROR;
            error_hold_in = 1'b1;
            pending_in    = '0;
         end else if (is_ws) begin
            ws_wr.en      = 1'b1;
            wr_ptr_in     = wr_ptr_ff + WS_PTR_W'(1);
            pending_in    = pending_ff + WS_CNT_W'(1);
            line_count_in = line_count_ff + 16'd1;
         end else if (req_tdata == CHAR_NEWLINE) begin
            // A blank line right after another blank line is squeezed out.
            q_push         = 1'b1;
            q_cmd.kind     = (has_content_ff || !prev_blank_ff) ? CMD_NEWLINE : CMD_SYNC;
            prev_blank_in  = !has_content_ff;
            pending_in     = '0;
            has_content_in = 1'b0;
            line_count_in  = '0;
         end else begin
            q_push         = 1'b1;
            q_cmd.kind     = CMD_CONTENT;
            q_cmd.start    = wr_ptr_ff - WS_PTR_W'(pending_ff);
            q_cmd.count    = pending_ff;
            pending_in     = '0;
            has_content_in = 1'b1;
            line_count_in  = line_count_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff     <= '0;
         has_content_ff <= 1'b0;
         prev_blank_ff  <= 1'b0;
         line_count_ff  <= '0;
         error_hold_ff  <= 1'b0;
         wr_ptr_ff      <= '0;
         max_len_ff     <= MAX_LINE_RESET;
      end else begin
         pending_ff     <= pending_in;
         has_content_ff <= has_content_in;
         prev_blank_ff  <= prev_blank_in;
         line_count_ff  <= line_count_in;
         error_hold_ff  <= error_hold_in;
         wr_ptr_ff      <= wr_ptr_in;
         max_len_ff     <= max_len_in;
      end
   end

endmodule

FILE: src/twt_cmd_queue.sv
// Short command queue between the front and back parts of the trimmer.
// Depends on twt_pkg.
module twt_cmd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  twt_pkg::twt_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output twt_pkg::twt_cmd_type head_cmd
);
   import twt_pkg::*;

   twt_cmd_type         slot_ff [QUEUE_DEPTH];
   logic [Q_ADDR_W-1:0] wr_ff, wr_in;
   logic [Q_ADDR_W-1:0] rd_ff, rd_in;
   logic [Q_ADDR_W:0]   level_ff, level_in;
   logic                do_push, do_pop;

   assign full       = (level_ff == (Q_ADDR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (level_ff != '0);
   assign head_cmd   = slot_ff[rd_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_in    = do_push ? wr_ff + Q_ADDR_W'(1) : wr_ff;
      rd_in    = do_pop ? rd_ff + Q_ADDR_W'(1) : rd_ff;
      level_in = level_ff + (Q_ADDR_W+1)'(do_push) - (Q_ADDR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         level_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         level_ff <= level_in;
      end
   end

endmodule

FILE: src/twt_back.sv
// Back part of the trimmer: holds the whitespace run buffer, carries out
// queued commands and drives the registered response. Depends on twt_pkg.
module twt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  twt_pkg::twt_ws_wr_type     ws_wr,
   input  logic                       q_valid,
   input  twt_pkg::twt_cmd_type       q_cmd,
   output logic                       q_pop,
   output twt_pkg::twt_back_stat_type back_stat,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [7:0]                 rsp_tdata,
   output logic [2:0]                 rsp_tuser,
   output logic                       rsp_tlast
);
   import twt_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_BYTE
   } state_type;

   logic [1:0]          ws_mem [WS_BUF_DEPTH];
   logic [1:0]          rd_data_ff;

   state_type           state_ff, state_in;
   logic [WS_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [WS_CNT_W-1:0] remaining_ff, remaining_in;
   logic [7:0]          cur_byte_ff, cur_byte_in;
   logic [WS_PTR_W-1:0] tail_ff, tail_in;
   logic                out_valid_ff, out_valid_in;
   logic [7:0]          out_data_ff, out_data_in;
   logic [2:0]          out_user_ff, out_user_in;
   logic                out_last_ff, out_last_in;
   logic                can_load;

   assign can_load       = !out_valid_ff || rsp_tready;
   assign back_stat.tail = tail_ff;
   assign rsp_tvalid     = out_valid_ff;
   assign rsp_tdata      = out_data_ff;
   assign rsp_tuser      = out_user_ff;
   assign rsp_tlast      = out_last_ff;

   // The read port follows the next read pointer, so rd_data_ff always
   // holds the entry at rd_ptr_ff once a run has started.
   always_ff @(posedge clock) begin
      if (ws_wr.en) begin
         ws_mem[ws_wr.addr] <= ws_wr.code;
      end
      rd_data_ff <= ws_mem[rd_ptr_in[WS_ADDR_W-1:0]];
   end

   always_comb begin
      state_in     = state_ff;
      rd_ptr_in    = rd_ptr_ff;
      remaining_in = remaining_ff;
      cur_byte_in  = cur_byte_ff;
      tail_in      = tail_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_user_in  = out_user_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  CMD_SYNC: begin
                     q_pop   = 1'b1;
                     tail_in = q_cmd.start;
                  end
                  CMD_NEWLINE, CMD_EOF, CMD_ERROR: begin
                     if (can_load) begin
                        q_pop        = 1'b1;
                        tail_in      = q_cmd.start;
                        out_valid_in = 1'b1;
                        out_last_in  = 1'b1;
                        if (q_cmd.kind == CMD_NEWLINE) begin
                           out_data_in = CHAR_NEWLINE;
                           out_user_in = {STATUS_NORMAL, 1'b1};
                        end else begin
                           out_data_in = 8'd0;
                           out_user_in = (q_cmd.kind == CMD_EOF) ? {STATUS_EOF, 1'b0} :
                                                                  {STATUS_ERROR, 1'b0};
                        end
                     end
                  end
                  CMD_CONTENT: begin
                     if (q_cmd.count == '0) begin
                        if (can_load) begin
                           q_pop        = 1'b1;
                           tail_in      = q_cmd.start;
                           out_valid_in = 1'b1;
                           out_last_in  = 1'b1;
                           out_data_in  = q_cmd.data;
                           out_user_in  = {STATUS_NORMAL, 1'b1};
                        end
                     end else begin
                        q_pop        = 1'b1;
                        rd_ptr_in    = q_cmd.start;
                        remaining_in = q_cmd.count;
                        cur_byte_in  = q_cmd.data;
                        state_in     = ST_RUN;
                     end
                  end
                  default: begin
                     q_pop = 1'b1;
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b0;
               out_data_in  = code_to_byte(rd_data_ff);
               out_user_in  = {STATUS_NORMAL, 1'b1};
               rd_ptr_in    = rd_ptr_ff + WS_PTR_W'(1);
               remaining_in = remaining_ff - WS_CNT_W'(1);
               if (remaining_ff == WS_CNT_W'(1)) begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_BYTE: begin
            if (can_load) begin
               out_valid_in = 1'b1;
               out_last_in  = 1'b1;
               out_data_in  = cur_byte_ff;
               out_user_in  = {STATUS_NORMAL, 1'b1};
               tail_in      = rd_ptr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_ptr_ff    <= '0;
         remaining_ff <= '0;
         tail_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_ptr_ff    <= rd_ptr_in;
         remaining_ff <= remaining_in;
         tail_ff      <= tail_in;
         out_valid_ff <= out_valid_in;
      end
      cur_byte_ff <= cur_byte_in;
      out_data_ff <= out_data_in;
      out_user_ff <= out_user_in;
      out_last_ff <= out_last_in;
   end

endmodule

FILE: src/trailing_whitespace_trimmer_core.sv
// Top level of the trailing whitespace trimmer with blank line squeeze.
// Instantiates twt_front, twt_cmd_queue and twt_back; depends on twt_pkg.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_tvalid/tready    | tdata byte, tuser end of file
//   rsp     | out       | rsp_tvalid/tready    | tdata byte, tuser valid+status, tlast
//   csr     | in        | csr_wr_en            | csr_wr_data line length limit
//
// The front takes one request per cycle when the command queue and the run
// buffer have room; whitespace only enters the 64-entry run buffer.
// For a content byte behind a held run, the back part's idle state opens the
// run, the run state releases the held characters and the byte state sends
// the content; the single response register paces it. Other results go out from idle.
// Reset is synchronous and active high; it clears all control state and sets
// the line length limit to 2000. Either side may stall on its own: the
// four-deep queue decouples them, and a stalled response holds its value.
module trailing_whitespace_trimmer_core (
   input  logic        clock,
   input  logic        reset,
   // Configuration: line length limit, written whenever csr_wr_en is high.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Requests.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] end_of_file
   // Responses.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [2:0]  rsp_tuser,   // [0] byte_valid, [2:1] status
   output logic        rsp_tlast    // last_of_run
);
   import twt_pkg::*;

   // Classified requests flow front to back through the queue.
   logic              q_full;
   logic              q_push;
   twt_cmd_type       q_push_cmd;
   logic              q_pop;
   logic              q_valid;
   twt_cmd_type       q_head;

   // Held whitespace codes are written by the front, read by the back, and
   // the back reports how far it has consumed the run buffer.
   twt_ws_wr_type     ws_wr;
   twt_back_stat_type back_stat;

   twt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_cmd       (q_push_cmd),
      .ws_wr       (ws_wr),
      .back_stat   (back_stat)
   );

   twt_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_head)
   );

   twt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .ws_wr      (ws_wr),
      .q_valid    (q_valid),
      .q_cmd      (q_head),
      .q_pop      (q_pop),
      .back_stat  (back_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/twt_checker.sv
// Port-level checks for the trimmer, attached to the top level by bind.
// Depends on twt_pkg and trailing_whitespace_trimmer_core.
module twt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [2:0] rsp_tuser,
   input logic       rsp_tlast
);
   import twt_pkg::*;

   // A response waiting for the consumer keeps its whole payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // Text bytes come exactly with normal status, never with another status.
   a_valid_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tuser[2:1] == STATUS_NORMAL)) &&
      (rsp_tuser[2:1] != 2'd3))
      else $error("byte flag disagrees with status");

   // End of file and error results are lone, empty and close their request.
   a_status_lone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:1] != STATUS_NORMAL) |->
      rsp_tlast && (rsp_tdata == 8'd0))
      else $error("status result is not a lone empty result");

   // Nothing is offered in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response offered right after reset");

endmodule

bind trailing_whitespace_trimmer_core twt_checker u_twt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

FILE: bench/trailing_whitespace_trimmer_core_test.sv
`timescale 1ns / 1ps
// Self-checking bench for trailing_whitespace_trimmer_core: directed table, then random files.
// Depends on twt_pkg and the trimmer RTL; holds its own trimming predictor.
module trailing_whitespace_trimmer_core_test;
   import twt_pkg::*;

   localparam int STALL_LIMIT = 2000;  // cycles with no handshake before giving up
   localparam int HOLD_CYCLES = 200;   // long receiver hold-off
   localparam int IDLE_WAIT   = 20;    // settle time before a register write
   localparam int END_WAIT    = 70;    // a full 63-deep run release plus margin

   // One response of the trimmer.
   typedef struct packed {
      logic [7:0] text;
      logic       valid;
      logic [1:0] status;
      logic       last;
   } trim_out_type;

   // Directed table: a request byte, an end of file mark or a limit write, and
   // how its outcome is known (typed in here, or worked out by the predictor).
   typedef enum logic [1:0] {ROW_BYTE, ROW_EOF, ROW_CFG} row_kind_type;
   typedef enum logic [1:0] {EXP_PREDICT, EXP_NONE, EXP_EOF, EXP_ERROR} exp_kind_type;
   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  value;
      exp_kind_type check;
   } row_type;

   row_type directed_rows [29] = '{
      '{ROW_EOF,  16'h0000,          EXP_EOF},      // end of file on an empty stream
      '{ROW_BYTE, 16'h0041,          EXP_PREDICT},
      '{ROW_BYTE, 16'(CHAR_SPACE),   EXP_NONE},     // whitespace is only held
      '{ROW_BYTE, 16'(CHAR_TAB),     EXP_NONE},
      '{ROW_BYTE, 16'(CHAR_VTAB),    EXP_NONE},
      '{ROW_BYTE, 16'h00FF,          EXP_PREDICT},  // held run released ahead of content
      '{ROW_BYTE, 16'(CHAR_SPACE),   EXP_NONE},
      '{ROW_BYTE, 16'(CHAR_NEWLINE), EXP_PREDICT},  // trailing space dropped
      '{ROW_BYTE, 16'(CHAR_NEWLINE), EXP_PREDICT},  // first blank line kept
      '{ROW_BYTE, 16'(CHAR_NEWLINE), EXP_NONE},     // second blank line squeezed
      '{ROW_BYTE, 16'h0000,          EXP_PREDICT},  // NUL is content
      '{ROW_BYTE, 16'h000D,          EXP_PREDICT},  // so is carriage return
      '{ROW_EOF,  16'h0000,          EXP_EOF},      // unterminated last line
      '{ROW_CFG,  16'd2,             EXP_NONE},
      '{ROW_BYTE, 16'h0061,          EXP_PREDICT},
      '{ROW_BYTE, 16'(CHAR_TAB),     EXP_NONE},
      '{ROW_BYTE, 16'h0062,          EXP_ERROR},    // line already at the limit
      '{ROW_BYTE, 16'h0063,          EXP_NONE},     // ignored while the error holds
      '{ROW_EOF,  16'h0000,          EXP_EOF},      // end of file clears the error
      '{ROW_CFG,  16'd0,             EXP_NONE},
      '{ROW_BYTE, 16'(CHAR_NEWLINE), EXP_ERROR},    // zero limit: every byte fails
      '{ROW_EOF,  16'h0000,          EXP_EOF},
      '{ROW_CFG,  16'd1,             EXP_NONE},
      '{ROW_BYTE, 16'(CHAR_NEWLINE), EXP_PREDICT},
      '{ROW_BYTE, 16'h007E,          EXP_PREDICT},
      '{ROW_BYTE, 16'(CHAR_SPACE),   EXP_ERROR},    // whitespace also counts toward the limit
      '{ROW_EOF,  16'h0000,          EXP_EOF},
      '{ROW_CFG,  16'd65535,         EXP_NONE},
      '{ROW_EOF,  16'h0000,          EXP_EOF}
   };

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = 16'h0000;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [7:0]  rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   // Predictor state, a copy of what the block keeps for the current file.
   logic [7:0]  held_blanks [WS_DEPTH];
   int          held_count   = 0;
   bit          has_content  = 1'b0;
   bit          prev_blank   = 1'b0;
   int          line_count   = 0;
   bit          err_hold     = 1'b0;
   logic [15:0] line_limit   = MAX_LINE_RESET;

   trim_out_type step_q [$];     // results of the request just predicted
   trim_out_type trimmed_q [$];  // trimmed text still to arrive, oldest first

   bit          send_quiet  = 1'b0;
   bit          recv_quiet  = 1'b0;
   bit          hold_req    = 1'b0;
   int          stall_left  = 0;
   int          idle_cycles = 0;
   int          errors      = 0;
   int          n_items     = 0;
   int          n_limits    = 0;
   int          n_bytes_out = 0;
   int          n_eof_out   = 0;
   int          n_err_out   = 0;
   int          longest_burst = 0;

   trailing_whitespace_trimmer_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic bit is_blank(input logic [7:0] c);
      return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_VTAB;
   endfunction

   // Works out the results of one accepted request and advances the copy of
   // the block's state. Results land in step_q.
   function automatic void trim_byte(input logic [7:0] c, input logic eof);
      bit emit;
      step_q.delete();
      if (eof) begin
         // End of file drops the held run and clears everything, errors too.
         held_count  = 0;
         has_content = 1'b0;
         prev_blank  = 1'b0;
         line_count  = 0;
         err_hold    = 1'b0;
         step_q.push_back('{8'h00, 1'b0, STATUS_EOF, 1'b0});
      end else if (err_hold) begin
         // The rest of a failed file is swallowed.
      end else if (line_count >= line_limit) begin
         err_hold = 1'b1;
         step_q.push_back('{8'h00, 1'b0, STATUS_ERROR, 1'b0});
      end else if (is_blank(c)) begin
         if (held_count >= WS_DEPTH) begin
            err_hold = 1'b1;
            step_q.push_back('{8'h00, 1'b0, STATUS_ERROR, 1'b0});
         end else begin
            held_blanks[held_count] = c;
            held_count++;
            line_count++;
         end
      end else if (c == CHAR_NEWLINE) begin
         // A blank line is kept only when the line before it was not blank.
         emit = 1'b1;
         if (has_content) prev_blank = 1'b0;
         else if (prev_blank) emit = 1'b0;
         else prev_blank = 1'b1;
         held_count  = 0;
         has_content = 1'b0;
         line_count  = 0;
         if (emit) step_q.push_back('{CHAR_NEWLINE, 1'b1, STATUS_NORMAL, 1'b0});
      end else begin
         for (int i = 0; i < held_count; i++)
            step_q.push_back('{held_blanks[i], 1'b1, STATUS_NORMAL, 1'b0});
         step_q.push_back('{c, 1'b1, STATUS_NORMAL, 1'b0});
         held_count  = 0;
         has_content = 1'b1;
         line_count++;
      end
      if (step_q.size() > 0) step_q[$].last = 1'b1;
   endfunction

   // Gap length: mostly short, now and then long.
   function automatic int pick_gap();
      if ($urandom_range(0, 5) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(0, 2))
         0:       return CHAR_SPACE;
         1:       return CHAR_TAB;
         default: return CHAR_VTAB;
      endcase
   endfunction

   function automatic logic [7:0] pick_content();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (is_blank(c) || c == CHAR_NEWLINE);
      return c;
   endfunction

   // Offers one request, waits for the handshake, then records what should
   // come back for it.
   task automatic send_request(input logic [7:0] d, input logic eof, input exp_kind_type check);
      int gap;
      gap = (!send_quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= eof;
      do @(posedge clock); while (!req_tready);
      trim_byte(d, eof);
      if (step_q.size() > longest_burst) longest_burst = step_q.size();
      case (check)
         EXP_PREDICT: foreach (step_q[i]) trimmed_q.push_back(step_q[i]);
         EXP_EOF:     trimmed_q.push_back('{8'h00, 1'b0, STATUS_EOF, 1'b1});
         EXP_ERROR:   trimmed_q.push_back('{8'h00, 1'b0, STATUS_ERROR, 1'b1});
         default: ;
      endcase
      n_items++;
   endtask

   task automatic send_blanks(input int n);
      repeat (n) send_request(pick_blank(), 1'b0, EXP_PREDICT);
   endtask

   // Stops sending until every expected response is in, then lets requests
   // that cause nothing drain out of the block.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (trimmed_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic set_line_limit(input logic [15:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      line_limit = v;
      n_limits++;
   endtask

   // One text file: lines of words with blank runs between and after them,
   // blank lines now and then, sometimes a run at the depth limit, and a few
   // files of raw noise. A file may end without its newline.
   task automatic send_file(input int deep);
      int  lines;
      int  words;
      bit  open_end;
      if (deep == 0 && $urandom_range(0, 14) == 0) deep = $urandom_range(1, 2);
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24))
            send_request(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                         EXP_PREDICT);
      end else begin
         // Depth one fills a run to the depth limit exactly; depth two overflows it.
         if (deep != 0) begin
            send_blanks(WS_DEPTH + deep - 1);
            if (deep == 1) send_request(pick_content(), 1'b0, EXP_PREDICT);
         end
         lines = $urandom_range(1, 5);
         for (int k = 0; k < lines; k++) begin
            if ($urandom_range(0, 4) == 0) begin
               send_blanks($urandom_range(0, 3));
            end else begin
               words = $urandom_range(1, 4);
               for (int w = 0; w < words; w++) begin
                  send_blanks(w == 0 ? $urandom_range(0, 2) : $urandom_range(1, 3));
                  repeat ($urandom_range(1, 6)) send_request(pick_content(), 1'b0, EXP_PREDICT);
               end
               send_blanks($urandom_range(0, 4));
            end
            open_end = (k == lines - 1) && $urandom_range(0, 2) == 0;
            if (!open_end) send_request(CHAR_NEWLINE, 1'b0, EXP_PREDICT);
         end
      end
      send_request(8'h00, 1'b1, EXP_PREDICT);
   endtask

   task automatic run_phase(input logic [15:0] limit, input int quota, input bit s_quiet,
                            input bit r_quiet, input bit hold, input bit forced_deep);
      int first;
      int files;
      set_line_limit(limit);
      send_quiet = s_quiet;
      recv_quiet = r_quiet;
      if (hold) hold_req = 1'b1;
      first = n_items;
      files = 0;
      while ((n_items - first < quota) || (forced_deep && files < 2)) begin
         send_file(forced_deep && files < 2 ? files + 1 : 0);
         files++;
         if (files == 1 && $urandom_range(0, 2) == 0) wait_idle();
      end
   endtask

   // Receiver: random stalls, plus one long hold-off on request so that the
   // block backs up all the way to its input.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         if (hold_req) begin
            stall_left = HOLD_CYCLES;
            hold_req   = 1'b0;
         end else if (!recv_quiet && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Every accepted response is checked against the oldest expectation.
   always @(posedge clock) begin : check_rsp
      trim_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser[0]) n_bytes_out++;
         if (rsp_tuser[2:1] == STATUS_EOF) n_eof_out++;
         if (rsp_tuser[2:1] == STATUS_ERROR) n_err_out++;
         if (trimmed_q.size() == 0) begin
            $error("response with nothing expected: tdata %0h tuser %0h tlast %0h",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            errors++;
         end else begin
            want = trimmed_q.pop_front();
            if (rsp_tdata !== want.text) begin
               $error("out_byte: expected %0h, got %0h", want.text, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[0] !== want.valid) begin
               $error("byte_valid: expected %0h, got %0h", want.valid, rsp_tuser[0]);
               errors++;
            end
            if (rsp_tuser[2:1] !== want.status) begin
               $error("status: expected %0h, got %0h", want.status, rsp_tuser[2:1]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %0h, got %0h", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Watchdog: too long without any handshake on either side means a hang.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: %0d cycles without a handshake, %0d responses missing",
                  idle_cycles, trimmed_q.size());
         $display("trailing_whitespace_trimmer_core_test: done, errors");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         case (directed_rows[r].kind)
            ROW_CFG: set_line_limit(directed_rows[r].value);
            ROW_EOF: send_request(8'h00, 1'b1, directed_rows[r].check);
            default: send_request(directed_rows[r].value[7:0], 1'b0, directed_rows[r].check);
         endcase
      end

      // Random files under a range of line limits, the extremes among them.
      run_phase(16'd65535, 100, 1'b0, 1'b0, 1'b0, 1'b1);
      run_phase(MAX_LINE_RESET, 20, 1'b1, 1'b0, 1'b1, 1'b0);
      run_phase(16'd1, 10, 1'b0, 1'b0, 1'b0, 1'b0);
      run_phase(16'd0, 8, 1'b0, 1'b0, 1'b0, 1'b0);
      run_phase(16'($urandom_range(2, 12)), 20, 1'b0, 1'b0, 1'b0, 1'b0);
      run_phase(16'($urandom_range(13, 80)), 20, 1'b1, 1'b1, 1'b0, 1'b0);

      req_tvalid <= 1'b0;
      while (trimmed_q.size() != 0) @(posedge clock);
      repeat (END_WAIT) @(posedge clock);

      $display("covered %0d requests under %0d line limits; %0d bytes out, longest burst %0d",
               n_items, n_limits, n_bytes_out, longest_burst);
      $display("end of file responses %0d, error responses %0d, mismatches %0d",
               n_eof_out, n_err_out, errors);
      if (errors == 0) begin
         $display("trailing_whitespace_trimmer_core_test: done, clean");
      end else begin
         $display("trailing_whitespace_trimmer_core_test: done, errors");
      end
      $finish;
   end

endmodule

FILE: files.f
src/twt_pkg.sv
src/twt_front.sv
src/twt_cmd_queue.sv
src/twt_back.sv
src/trailing_whitespace_trimmer_core.sv
src/twt_checker.sv
bench/trailing_whitespace_trimmer_core_test.sv
